@@ rtl/channel_subscriber_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// channel_subscriber_table_unit assertion macros
// Implication checks on the block clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_SUBSCRIBER_TABLE_UNIT_MACROS_SVH
`define CHANNEL_SUBSCRIBER_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CST_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("cst assertion failed");
// next-cycle implication
`define CST_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("cst assertion failed");
`else
`define CST_ASSERT_IMPL(lbl, clk, rst, a, b)
`define CST_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif

`endif

@@ rtl/cst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Types and codes shared by the channel subscriber table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int ID_W     = 16;
  localparam int CHAN_W   = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    OP_SUBSCRIBE   = 2'd0,
    OP_UNSUBSCRIBE = 2'd1,
    OP_UNSUB_ALL   = 2'd2,
    OP_PUBLISH     = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_SUB = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

endpackage

@@ rtl/cst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/channel_subscriber_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_subscriber_table_unit
// Per-channel subscriber table with subscribe, unsubscribe and publish.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results come out on
// valid, one cycle each, and cannot be held off, so the receiver must take a
// result in every cycle that valid is high. The table sits in one RAM with a
// single read port and is walked one slot a cycle, but for a read dropped by
// unsubscribe-all. Subscribe and unsubscribe stop at the first matching slot
// or the last slot of the channel, publish reads every slot and spreads its
// results over the walk, and unsubscribe-all moves on to the next channel once
// the id is removed from one. After reset busy stays high while the RAM is cleared.
module channel_subscriber_table_unit #(
  parameter int CHANNELS = 16,
  parameter int SLOTS    = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation,
  input  logic [cst_pkg::CHAN_W-1:0]   channel,
  input  logic [cst_pkg::ID_W-1:0]     subscriber,
  output logic                         valid,
  output logic [cst_pkg::STATUS_W-1:0] status,
  output logic                         has_target,
  output logic [cst_pkg::ID_W-1:0]     target_id,
  output logic [cst_pkg::CHAN_W-1:0]   target_channel,
  output logic                         last
);

  `include "channel_subscriber_table_unit_macros.svh"

  localparam int DEPTH = CHANNELS * SLOTS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int SW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam logic [CW-1:0] LAST_CHAN = CW'(CHANNELS - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  cst_pkg::state_t state, state_next;
  cst_pkg::op_t    op, op_next;

  logic [cst_pkg::CHAN_W-1:0] req_chan, req_chan_next;
  logic [cst_pkg::ID_W-1:0]   sub_id, sub_id_next;
  logic                       rd_active, rd_active_next;
  logic [CW-1:0]              rd_chan, rd_chan_next;
  logic [SW-1:0]              rd_slot, rd_slot_next;
  logic                       d_valid, d_valid_next;
  logic [AW-1:0]              d_addr, d_addr_next;
  logic [CW-1:0]              d_chan, d_chan_next;
  logic                       d_last_slot, d_last_slot_next;
  logic                       pend_valid, pend_valid_next;
  logic [cst_pkg::ID_W-1:0]   pend_id, pend_id_next;
  logic [AW-1:0]              clr_addr, clr_addr_next;

  logic                         valid_next, has_target_next, last_next;
  logic [cst_pkg::STATUS_W-1:0] status_next;
  logic [cst_pkg::ID_W-1:0]     target_id_next;
  logic [cst_pkg::CHAN_W-1:0]   target_channel_next;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [cst_pkg::ID_W-1:0] ram_wdata, ram_rdata;

  logic accept;
  logic in_range;
  logic match;

  cst_ram #(
    .WIDTH (cst_pkg::ID_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state != cst_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(channel) < 32'(CHANNELS));

  always_comb begin
    unique case (op)
      cst_pkg::OP_SUBSCRIBE: match = (ram_rdata == '0);
      default:               match = (ram_rdata == sub_id);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cst_pkg::S_CLEAR;
      clr_addr   <= '0;
      rd_active  <= 1'b0;
      d_valid    <= 1'b0;
      pend_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      rd_active  <= rd_active_next;
      d_valid    <= d_valid_next;
      pend_valid <= pend_valid_next;
      valid      <= valid_next;
    end
    op             <= op_next;
    req_chan       <= req_chan_next;
    sub_id         <= sub_id_next;
    rd_chan        <= rd_chan_next;
    rd_slot        <= rd_slot_next;
    d_addr         <= d_addr_next;
    d_chan         <= d_chan_next;
    d_last_slot    <= d_last_slot_next;
    pend_id        <= pend_id_next;
    status         <= status_next;
    has_target     <= has_target_next;
    target_id      <= target_id_next;
    target_channel <= target_channel_next;
    last           <= last_next;
  end

  always_comb begin
    state_next          = state;
    op_next             = op;
    req_chan_next       = req_chan;
    sub_id_next         = sub_id;
    rd_active_next      = rd_active;
    rd_chan_next        = rd_chan;
    rd_slot_next        = rd_slot;
    d_valid_next        = 1'b0;
    d_addr_next         = d_addr;
    d_chan_next         = d_chan;
    d_last_slot_next    = d_last_slot;
    pend_valid_next     = pend_valid;
    pend_id_next        = pend_id;
    clr_addr_next       = clr_addr;
    valid_next          = 1'b0;
    status_next         = cst_pkg::ST_OK;
    has_target_next     = 1'b0;
    target_id_next      = '0;
    target_channel_next = '0;
    last_next           = 1'b1;
    ram_we              = 1'b0;
    ram_waddr           = d_addr;
    ram_wdata           = '0;
    ram_raddr           = AW'(32'(rd_chan) * SLOTS + 32'(rd_slot));

    unique case (state)
      cst_pkg::S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = cst_pkg::S_IDLE;
        end
      end

      cst_pkg::S_IDLE: begin
        if (accept) begin
          op_next         = cst_pkg::op_t'(operation);
          req_chan_next   = channel;
          sub_id_next     = subscriber;
          pend_valid_next = 1'b0;
          rd_slot_next    = '0;
          if (cst_pkg::op_t'(operation) == cst_pkg::OP_UNSUB_ALL) begin
            rd_chan_next   = '0;
            rd_active_next = 1'b1;
            state_next     = cst_pkg::S_SCAN;
          end else if (in_range) begin
            rd_chan_next   = CW'(channel);
            rd_active_next = 1'b1;
            state_next     = cst_pkg::S_SCAN;
          end else begin
            // channel with no slots: answer at once, table untouched
            valid_next = 1'b1;
            unique case (cst_pkg::op_t'(operation))
              cst_pkg::OP_SUBSCRIBE:   status_next = cst_pkg::ST_FULL;
              cst_pkg::OP_UNSUBSCRIBE: status_next = cst_pkg::ST_NOT_SUB;
              default:                 target_channel_next = channel;
            endcase
          end
        end
      end

      cst_pkg::S_SCAN: begin
        // read issue stage
        if (rd_active) begin
          d_valid_next     = 1'b1;
          d_addr_next      = ram_raddr;
          d_chan_next      = rd_chan;
          d_last_slot_next = (rd_slot == LAST_SLOT);
          if (rd_slot == LAST_SLOT) begin
            rd_slot_next = '0;
            if (op == cst_pkg::OP_UNSUB_ALL && rd_chan != LAST_CHAN) begin
              rd_chan_next = rd_chan + CW'(1);
            end else begin
              rd_active_next = 1'b0;
            end
          end else begin
            rd_slot_next = rd_slot + SW'(1);
          end
        end

        // data stage, for the read issued the cycle before
        if (d_valid) begin
          unique case (op) inside
            cst_pkg::OP_SUBSCRIBE, cst_pkg::OP_UNSUBSCRIBE: begin
              if (match || d_last_slot) begin
                valid_next     = 1'b1;
                state_next     = cst_pkg::S_IDLE;
                rd_active_next = 1'b0;
                d_valid_next   = 1'b0;
                if (match) begin
                  ram_we    = 1'b1;
                  ram_wdata = (op == cst_pkg::OP_SUBSCRIBE) ? sub_id : '0;
                end else if (op == cst_pkg::OP_SUBSCRIBE) begin
                  status_next = cst_pkg::ST_FULL;
                end else begin
                  status_next = cst_pkg::ST_NOT_SUB;
                end
              end
            end

            cst_pkg::OP_UNSUB_ALL: begin
              if (match) begin
                ram_we = 1'b1;
              end
              if ((match || d_last_slot) && d_chan == LAST_CHAN) begin
                valid_next     = 1'b1;
                state_next     = cst_pkg::S_IDLE;
                rd_active_next = 1'b0;
                d_valid_next   = 1'b0;
              end else if (match) begin
                // drop the read in flight, restart on the next channel
                d_valid_next   = 1'b0;
                rd_chan_next   = d_chan + CW'(1);
                rd_slot_next   = '0;
                rd_active_next = 1'b1;
              end
            end

            default: begin
              // publish: hold one hit back so the final one can carry last
              if (ram_rdata != '0) begin
                if (pend_valid) begin
                  valid_next          = 1'b1;
                  has_target_next     = 1'b1;
                  target_id_next      = pend_id;
                  target_channel_next = req_chan;
                  last_next           = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_id_next    = ram_rdata;
              end
              if (d_last_slot) begin
                state_next = cst_pkg::S_FLUSH;
              end
            end
          endcase
        end
      end

      cst_pkg::S_FLUSH: begin
        valid_next          = 1'b1;
        has_target_next     = pend_valid;
        target_id_next      = pend_valid ? pend_id : '0;
        target_channel_next = req_chan;
        state_next          = cst_pkg::S_IDLE;
      end

      default: begin
        state_next = cst_pkg::S_IDLE;
      end
    endcase
  end

  `CST_ASSERT_IMPL(a_no_write_idle, clk, rst, state == cst_pkg::S_IDLE, !ram_we)
  `CST_ASSERT_IMPL(a_inner_has_target, clk, rst, valid && !last, has_target)
  `CST_ASSERT_NEXT(a_accept_progress, clk, rst, accept, busy || valid)

endmodule

@@ tb/channel_subscriber_table_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_subscriber_table_unit_test
// Drives subscribe, unsubscribe, unsubscribe-all and publish requests into
// the subscriber table, keeps a shadow copy of the table to work out every
// result, and checks each strobed result field by field in arrival order.
// ----------------------------------------------------------------------------
module channel_subscriber_table_unit_test;

  localparam int NCH   = 16;
  localparam int NSL   = 8;
  // clearing pass plus the longest unsubscribe-all, with margin
  localparam int DRAIN = NCH * NSL + NCH + 40;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [6:0]                 idle_pct;
    cst_pkg::op_t               op;
    logic [cst_pkg::CHAN_W-1:0] chan;
    logic [cst_pkg::ID_W-1:0]   id;
  } cst_request_t;

  typedef struct packed {
    logic [cst_pkg::STATUS_W-1:0] status;
    logic                         has_target;
    logic [cst_pkg::ID_W-1:0]     target_id;
    logic [cst_pkg::CHAN_W-1:0]   target_channel;
    logic                         last;
  } cst_result_t;

  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         start      = 1'b0;
  logic [1:0]                   operation  = '0;
  logic [cst_pkg::CHAN_W-1:0]   channel    = '0;
  logic [cst_pkg::ID_W-1:0]     subscriber = '0;
  logic                         busy;
  logic                         valid;
  logic [cst_pkg::STATUS_W-1:0] status;
  logic                         has_target;
  logic [cst_pkg::ID_W-1:0]     target_id;
  logic [cst_pkg::CHAN_W-1:0]   target_channel;
  logic                         last;

  channel_subscriber_table_unit #(
    .CHANNELS(NCH),
    .SLOTS   (NSL)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .channel       (channel),
    .subscriber    (subscriber),
    .valid         (valid),
    .status        (status),
    .has_target    (has_target),
    .target_id     (target_id),
    .target_channel(target_channel),
    .last          (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow table and traffic state
  logic [cst_pkg::ID_W-1:0] shadow_ids [NCH*NSL];
  cst_request_t             pending_requests [$];
  cst_result_t              expected_results [$];
  cst_request_t             active_req;
  logic                     present_now;
  int                       requests_taken = 0;
  int                       total_requests = 0;
  int                       errors = 0;

  function automatic void push_result(input logic [cst_pkg::STATUS_W-1:0] st,
                                      input logic has,
                                      input logic [cst_pkg::ID_W-1:0] id,
                                      input logic [cst_pkg::CHAN_W-1:0] ch,
                                      input logic lst);
    cst_result_t r;
    r.status         = st;
    r.has_target     = has;
    r.target_id      = id;
    r.target_channel = ch;
    r.last           = lst;
    expected_results.push_back(r);
  endfunction

  // empties the first slot holding the id; id zero matches an empty slot
  function automatic logic [cst_pkg::STATUS_W-1:0] drop_subscriber(
      input int ch, input logic [cst_pkg::ID_W-1:0] id);
    int s;
    if (ch >= NCH) return cst_pkg::ST_NOT_SUB;
    for (s = 0; s < NSL; s++) begin
      if (shadow_ids[ch*NSL+s] == id) begin
        shadow_ids[ch*NSL+s] = '0;
        return cst_pkg::ST_OK;
      end
    end
    return cst_pkg::ST_NOT_SUB;
  endfunction

  function automatic void apply_request(input cst_request_t rq);
    int                           c;
    int                           s;
    int                           occupied;
    int                           seen;
    logic [cst_pkg::STATUS_W-1:0] st;
    c = rq.chan;
    case (rq.op)
      cst_pkg::OP_SUBSCRIBE: begin
        st = cst_pkg::ST_FULL;
        if (c < NCH) begin
          for (s = 0; s < NSL; s++) begin
            if (st == cst_pkg::ST_FULL && shadow_ids[c*NSL+s] == '0) begin
              shadow_ids[c*NSL+s] = rq.id;
              st = cst_pkg::ST_OK;
            end
          end
        end
        push_result(st, 1'b0, '0, '0, 1'b1);
      end
      cst_pkg::OP_UNSUBSCRIBE: begin
        push_result(drop_subscriber(c, rq.id), 1'b0, '0, '0, 1'b1);
      end
      cst_pkg::OP_UNSUB_ALL: begin
        for (c = 0; c < NCH; c++) st = drop_subscriber(c, rq.id);
        push_result(cst_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
      end
      default: begin
        occupied = 0;
        if (c < NCH)
          for (s = 0; s < NSL; s++) if (shadow_ids[c*NSL+s] != '0) occupied++;
        if (occupied == 0) begin
          push_result(cst_pkg::ST_OK, 1'b0, '0, rq.chan, 1'b1);
        end else begin
          seen = 0;
          for (s = 0; s < NSL; s++) begin
            if (shadow_ids[c*NSL+s] != '0) begin
              seen++;
              push_result(cst_pkg::ST_OK, 1'b1, shadow_ids[c*NSL+s], rq.chan,
                          seen == occupied);
            end
          end
        end
      end
    endcase
  endfunction

  task automatic queue_request(input cst_pkg::op_t op, input int ch, input int id,
                               input int idle);
    cst_request_t rq;
    rq.idle_pct = 7'(idle);
    rq.op       = op;
    rq.chan     = cst_pkg::CHAN_W'(ch);
    rq.id       = cst_pkg::ID_W'(id);
    pending_requests.push_back(rq);
  endtask

  // mostly a few busy channels and a small id pool, so slots fill and
  // unsubscribes find their ids; the rest spans the whole field range
  task automatic queue_random_request(input int idle);
    int pick;
    int ch;
    int id;
    cst_pkg::op_t op;
    pick = $urandom_range(99);
    if (pick < 42)      op = cst_pkg::OP_SUBSCRIBE;
    else if (pick < 67) op = cst_pkg::OP_UNSUBSCRIBE;
    else if (pick < 74) op = cst_pkg::OP_UNSUB_ALL;
    else                op = cst_pkg::OP_PUBLISH;
    if ($urandom_range(99) < 70) ch = $urandom_range(3) * 5;
    else                         ch = $urandom_range(NCH - 1);
    pick = $urandom_range(99);
    if (pick < 60)      id = $urandom_range(10, 1);
    else if (pick < 64) id = 0;
    else                id = $urandom_range(65535);
    queue_request(op, ch, id, idle);
  endtask

  // driver: one request in flight on start, held until busy lets it in
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      present_now = start;
      if (start && !busy) begin
        apply_request(active_req);
        requests_taken++;
        present_now = 1'b0;
      end
      if (!present_now && pending_requests.size() > 0 &&
          $urandom_range(99) >= pending_requests[0].idle_pct) begin
        active_req  = pending_requests.pop_front();
        present_now = 1'b1;
      end
      start <= present_now;
      if (present_now) begin
        operation  <= active_req.op;
        channel    <= active_req.chan;
        subscriber <= active_req.id;
      end else begin
        // junk on the fields while no request is offered
        operation  <= 2'($urandom_range(3));
        channel    <= cst_pkg::CHAN_W'($urandom_range(NCH - 1));
        subscriber <= cst_pkg::ID_W'($urandom_range(65535));
      end
    end
  end

  // monitor: every strobe is taken against the oldest expectation
  always @(posedge clk) begin
    cst_result_t want;
    if (!rst && valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d target %0d id %0h channel %0d last %0d",
               status, has_target, target_id, target_channel, last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (has_target !== want.has_target) begin
          $error("has_target: expected %0d, got %0d", want.has_target, has_target);
          errors++;
        end
        if (target_id !== want.target_id) begin
          $error("target_id: expected %0h, got %0h", want.target_id, target_id);
          errors++;
        end
        if (target_channel !== want.target_channel) begin
          $error("target_channel: expected %0d, got %0d",
                 want.target_channel, target_channel);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("channel_subscriber_table_unit test failed");
    $finish;
  end

  initial begin
    int i;
    for (i = 0; i < NCH * NSL; i++) shadow_ids[i] = '0;

    // directed: empty channel, filling to full, duplicates, id zero,
    // unsubscribe-all across channels
    queue_request(cst_pkg::OP_PUBLISH,     0, 0,       30);
    queue_request(cst_pkg::OP_UNSUBSCRIBE, 0, 5,       30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 1,       30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 16'hFFFF, 30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 16'h8000, 30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 16'h7FFF, 30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 16'h5555, 30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 16'hAAAA, 30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 7,       30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 7,       30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 9,       30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 0,       30);
    queue_request(cst_pkg::OP_UNSUBSCRIBE, 0, 0,       30);
    queue_request(cst_pkg::OP_PUBLISH,     0, 16'hFFFF, 30);
    queue_request(cst_pkg::OP_UNSUBSCRIBE, 0, 7,       30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   0, 0,       30);
    queue_request(cst_pkg::OP_UNSUBSCRIBE, 0, 0,       30);
    queue_request(cst_pkg::OP_PUBLISH,     0, 0,       30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   15, 7,      30);
    queue_request(cst_pkg::OP_SUBSCRIBE,   9, 7,       30);
    queue_request(cst_pkg::OP_UNSUB_ALL,   15, 7,      30);
    queue_request(cst_pkg::OP_PUBLISH,     15, 0,      30);
    queue_request(cst_pkg::OP_PUBLISH,     0, 0,       30);

    for (i = 0; i < 50; i++) queue_random_request(0);
    for (i = 0; i < 50; i++) queue_random_request(80);
    for (i = 0; i < 50; i++) queue_random_request(21);
    total_requests = pending_requests.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (requests_taken < total_requests || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("channel_subscriber_table_unit test passed");
    end else begin
      $display("channel_subscriber_table_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_ram.sv
rtl/channel_subscriber_table_unit.sv
tb/channel_subscriber_table_unit_test.sv
